// File: sv/lpt_pkg.sv
// Package for the LRU page tracker: shared constants, the sequencer state
// encoding and the result flag bundle. No dependencies.
package lpt_pkg;

  // Fixed widths of the external fields.
  localparam int unsigned PAGE_W = 16;
  localparam int unsigned CFG_W  = 5;

  // Resident limit after reset.
  localparam int unsigned RESET_MAX_RESIDENT = 16;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_SHIFT  = 6'b000100,
    ST_MISS   = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_EVICT  = 6'b100000
  } lpt_state_e;

  typedef struct packed {
    logic hit;
    logic evict_valid;
    logic last;
  } res_flags_t;

endpackage

// File: sv/lpt_list_mem.sv
// Recency list storage: simple dual-port synchronous RAM, one write and one
// registered read per cycle. No dependencies.
module lpt_list_mem #(
  parameter int unsigned AW = 5,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lpt_ctrl.sv
// Sequencer of the LRU page tracker: searches, reorders and evicts entries
// of the recency list held in lpt_list_mem. Depends on lpt_pkg.
module lpt_ctrl #(
  parameter int unsigned PAGE_ID_BITS = 16,
  parameter int unsigned CW           = 5,
  parameter int unsigned AW           = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [PAGE_ID_BITS-1:0] in_page_i,
  output logic                    in_stall_o,
  input  logic [CW-1:0]           lim_i,
  output logic                    mem_re_o,
  output logic [AW-1:0]           mem_raddr_o,
  input  logic [PAGE_ID_BITS-1:0] mem_rdata_i,
  output logic                    mem_we_o,
  output logic [AW-1:0]           mem_waddr_o,
  output logic [PAGE_ID_BITS-1:0] mem_wdata_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output lpt_pkg::res_flags_t     res_flags_o,
  output logic [PAGE_ID_BITS-1:0] res_page_o
);
  import lpt_pkg::*;

  lpt_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] base_q, base_d;
  logic [PAGE_ID_BITS-1:0] page_q, page_d;
  logic [CW-1:0] issue_q, issue_d;
  logic pend_q, pend_d;
  logic [CW-1:0] pend_idx_q, pend_idx_d;
  logic [CW-1:0] last_idx;
  logic evict_last;

  assign last_idx   = count_q - CW'(1);
  assign evict_last = (last_idx <= lim_i);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    base_d      = base_q;
    page_d      = page_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = base_q + issue_q[AW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = base_q + pend_idx_q[AW-1:0];
    mem_wdata_o = page_q;
    res_valid_o = 1'b0;
    res_flags_o = '0;
    res_page_o  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          page_d  = in_page_i;
          issue_d = '0;
          pend_d  = 1'b0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // One entry is read per cycle; its data is compared the cycle after.
        if (pend_q && (mem_rdata_i == page_q)) begin
          issue_d = pend_idx_q + CW'(1);
          pend_d  = 1'b0;
          state_d = ST_SHIFT;
        end else if ((count_q == '0) || (pend_q && (pend_idx_q == last_idx))) begin
          pend_d  = 1'b0;
          state_d = ST_MISS;
        end else if (issue_q < count_q) begin
          mem_re_o   = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = issue_q;
          issue_d    = issue_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_SHIFT: begin
        // Entries above the hit move down one place: read at i, write at i-1.
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = base_q + pend_idx_q[AW-1:0];
          mem_wdata_o = mem_rdata_i;
        end
        if (issue_q < count_q) begin
          mem_re_o   = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = issue_q - CW'(1);
          issue_d    = issue_q + CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else if (res_ready_i) begin
          mem_we_o        = 1'b1;
          mem_waddr_o     = base_q + last_idx[AW-1:0];
          mem_wdata_o     = page_q;
          res_valid_o     = 1'b1;
          res_flags_o.hit  = 1'b1;
          res_flags_o.last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_MISS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = base_q + count_q[AW-1:0];
        mem_wdata_o = page_q;
        count_d     = count_q + CW'(1);
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (count_q > lim_i) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = base_q;
          state_d     = ST_EVICT;
        end else if (res_ready_i) begin
          res_valid_o      = 1'b1;
          res_flags_o.last = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_EVICT: begin
        // The oldest entry leaves by advancing the ring base.
        if (res_ready_i) begin
          res_valid_o             = 1'b1;
          res_flags_o.evict_valid = 1'b1;
          res_flags_o.last        = evict_last;
          res_page_o              = mem_rdata_i;
          base_d                  = base_q + AW'(1);
          count_d                 = last_idx;
          state_d                 = evict_last ? ST_IDLE : ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      base_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      base_q  <= base_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
  end

endmodule

// File: sv/lru_page_tracker_unit.sv
// LRU page tracker top level: limit register, result register, list RAM and
// sequencer. The search reads one entry per cycle and a hit copies the entries
// above it down one per cycle. A miss may be followed by further evictions, and
// output stalls delay every result. One item at a time. Reset empties the list
// and sets the limit to 16, or to LIST_DEPTH if smaller; RAM is not cleared.
module lru_page_tracker_unit #(
  parameter int unsigned LIST_DEPTH   = 16,
  parameter int unsigned PAGE_ID_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lpt_pkg::PAGE_W-1:0] page_id_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic                       evict_valid_o,
  output logic [lpt_pkg::PAGE_W-1:0] evicted_page_o,
  output logic                       last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lpt_pkg::CFG_W-1:0]  cfg_max_resident_i
);
  import lpt_pkg::*;

  localparam int unsigned CW = $clog2(LIST_DEPTH + 2);
  localparam int unsigned AW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned LIM_RST =
    (RESET_MAX_RESIDENT > LIST_DEPTH) ? LIST_DEPTH : RESET_MAX_RESIDENT;

  logic [CW-1:0] lim_q;
  logic [LW-1:0] cfg_ext;
  logic [LW-1:0] lim_clamped;

  logic                    mem_re, mem_we;
  logic [AW-1:0]           mem_raddr, mem_waddr;
  logic [PAGE_ID_BITS-1:0] mem_rdata, mem_wdata;

  logic                    res_valid, res_ready;
  res_flags_t              res_flags;
  logic [PAGE_ID_BITS-1:0] res_page;

  logic                    out_valid_q;
  res_flags_t              out_flags_q;
  logic [PAGE_W-1:0]       out_page_q;

  // A limit of zero acts as one; above the list depth it saturates.
  assign cfg_ext = LW'(cfg_max_resident_i);
  always_comb begin
    if (cfg_ext == '0) begin
      lim_clamped = LW'(1);
    end else if (cfg_ext > LW'(LIST_DEPTH)) begin
      lim_clamped = LW'(LIST_DEPTH);
    end else begin
      lim_clamped = cfg_ext;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= CW'(LIM_RST);
    end else if (cfg_valid_i) begin
      lim_q <= lim_clamped[CW-1:0];
    end
  end

  lpt_list_mem #(
    .AW (AW),
    .DW (PAGE_ID_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lpt_ctrl #(
    .PAGE_ID_BITS (PAGE_ID_BITS),
    .CW           (CW),
    .AW           (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_page_i   (PAGE_ID_BITS'(page_id_i)),
    .in_stall_o  (in_stall_o),
    .lim_i       (lim_q),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_flags_o (res_flags),
    .res_page_o  (res_page)
  );

  // Result register: a new result loads when the slot is empty or its
  // transfer completes in this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_flags_q <= res_flags;
      out_page_q  <= PAGE_W'(res_page);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_flags_q.hit;
  assign evict_valid_o  = out_flags_q.evict_valid;
  assign last_o         = out_flags_q.last;
  assign evicted_page_o = out_page_q;

endmodule
